// ----- rtl/aba_pkg.sv -----
package aba_pkg;

	localparam int ADDR_W_DEF = 32;
	localparam int DATA_W     = 32;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_RESIZE  = 3'd1;
	localparam logic [OP_W-1:0] OP_RESET   = 3'd2;
	localparam logic [OP_W-1:0] OP_READ    = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTORE = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALIGN = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ROOM  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 1'd1;

	localparam logic [DATA_W-1:0] CAP_RESET = 32'd65536;

	typedef struct packed {
		logic load;
		logic step1;
		logic step2;
		logic commit;
	} aba_cmd_t;

endpackage

// ----- rtl/aba_datapath.sv -----
module aba_datapath
	import aba_pkg::*;
#(
	parameter int ADDRESS_WIDTH = ADDR_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aba_cmd_t             cmd,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic [OP_W-1:0]      op,
	input  logic [DATA_W-1:0]    alloc_size,
	input  logic [DATA_W-1:0]    alignment,
	input  logic [DATA_W-1:0]    blk_address,
	input  logic [DATA_W-1:0]    blk_size,
	input  logic [DATA_W-1:0]    marker_prev,
	input  logic [DATA_W-1:0]    marker_curr,
	output logic [STATUS_W-1:0]  status,
	output logic [DATA_W-1:0]    address,
	output logic [DATA_W-1:0]    saved_prev,
	output logic [DATA_W-1:0]    saved_curr
);

	// absolute addresses wrap at the address width, only the low word is ever seen
	localparam logic [DATA_W-1:0] AM32 = (ADDRESS_WIDTH >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);

	logic [DATA_W-1:0] base_q, cap_q, last_q, top_q;

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] size_q, align_q, oaddr_q, osz_q, mprev_q, mcurr_q;

	// first step
	logic [DATA_W-1:0] cur_s1, amask_s1, ooff_s1, trs_s1;
	logic [DATA_W:0]   tps_s1;
	logic              pow2_s1, below_s1, null_s1, zero_s1, eq_s1;

	// second step
	logic [DATA_W-1:0] pad_s2, top_rs_s2;
	logic              addr_bad_s2, room_rs_s2, inplace_s2;

	logic [STATUS_W-1:0] st_d;
	logic [DATA_W-1:0]   addr_d, last_d, top_d, alloc_addr;
	logic [DATA_W-1:0]   off;
	logic [DATA_W+1:0]   fin;
	logic                room_al, use_alloc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			cap_q  <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE: base_q <= cfg_data;
				CFG_CAP:  cap_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			size_q  <= alloc_size;
			align_q <= alignment;
			oaddr_q <= blk_address;
			osz_q   <= blk_size;
			mprev_q <= marker_prev;
			mcurr_q <= marker_curr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step1) begin
			cur_s1             <= (base_q + top_q) & AM32;
			amask_s1           <= align_q - 32'd1;
			pow2_s1            <= (align_q != '0) && ((align_q & (align_q - 32'd1)) == '0);
			{below_s1, ooff_s1} <= {1'b0, oaddr_q} - {1'b0, base_q};
			null_s1            <= (oaddr_q == '0);
			zero_s1            <= (osz_q == '0) || (size_q == '0);
			eq_s1              <= (osz_q == size_q);
			tps_s1             <= {1'b0, top_q} + {1'b0, size_q};
			trs_s1             <= top_q + size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step2) begin
			pad_s2      <= (32'd0 - cur_s1) & amask_s1;
			addr_bad_s2 <= null_s1 || below_s1 || (ooff_s1 >= cap_q);
			room_rs_s2  <= (size_q > (cap_q - ooff_s1));
			inplace_s2  <= (ooff_s1 == last_q);
			top_rs_s2   <= trs_s1 - osz_q;
		end
	end

	// aligned start, and end of the block computed exactly; the start only
	// matters when the end fits, so its low word is enough
	assign off        = top_q + pad_s2;
	assign fin        = {1'b0, tps_s1} + {2'b00, pad_s2};
	assign room_al    = (fin > {2'b00, cap_q});
	assign alloc_addr = (cur_s1 + pad_s2) & AM32;

	always_comb begin
		st_d      = ST_OK;
		addr_d    = '0;
		last_d    = last_q;
		top_d     = top_q;
		use_alloc = 1'b0;
		case (op_q)
			OP_ALLOC: use_alloc = 1'b1;
			OP_RESIZE: begin
				if (addr_bad_s2) begin
					st_d = ST_ADDR;
				end else if (zero_s1) begin
					st_d = ST_ZERO;
				end else if (!pow2_s1) begin
					st_d = ST_ALIGN;
				end else if (eq_s1) begin
					addr_d = oaddr_q;
				end else if (room_rs_s2) begin
					st_d = ST_ROOM;
				end else if (inplace_s2) begin
					top_d  = top_rs_s2;
					addr_d = oaddr_q;
				end else begin
					use_alloc = 1'b1;
				end
			end
			OP_RESET: begin
				last_d = '0;
				top_d  = '0;
			end
			OP_READ: ;
			OP_RESTORE: begin
				last_d = mprev_q;
				top_d  = mcurr_q;
			end
			default: ;
		endcase
		if (use_alloc) begin
			if (!pow2_s1) begin
				st_d = ST_ALIGN;
			end else if (room_al) begin
				st_d = ST_ROOM;
			end else begin
				addr_d = alloc_addr;
				last_d = off;
				top_d  = fin[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			top_q  <= '0;
		end else if (cmd.commit) begin
			last_q <= last_d;
			top_q  <= top_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status     <= st_d;
			address    <= addr_d;
			saved_prev <= last_d;
			saved_curr <= top_d;
		end
	end

endmodule

// ----- rtl/aba_ctrl.sv -----
module aba_ctrl
	import aba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output aba_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_C1   = 2'd1;
	localparam logic [1:0] S_C2   = 2'd2;
	localparam logic [1:0] S_C3   = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;

	assign cmd.load   = s_tready && s_tvalid;
	assign cmd.step1  = (state_q == S_C1);
	assign cmd.step2  = (state_q == S_C2);
	// last step waits until the output register is free
	assign cmd.commit = (state_q == S_C3) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_C1;
			S_C1:    state_d = S_C2;
			S_C2:    state_d = S_C3;
			S_C3:    if (cmd.commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_C1)
		else $error("accepted word did not start the sequence");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C3 && m_tvalid && !m_tready) |=> state_q == S_C3)
		else $error("result overwritten while output stalled");

	a_c2_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_C2 |-> $past(state_q) == S_C1)
		else $error("step order broken");

endmodule

// ----- rtl/arena_bump_allocator.sv -----
// arena bump allocator: hands out aligned blocks from an arena at a
// configured base address and capacity, tracking the last block start and
// the first free offset.
// input channel s_*: one request word per handshake, op code in tuser.
// output channel m_*: one result word per request, status code in tuser.
// cfg_*: register writes (base address, capacity), always ready; write only
// while no request is in flight.
// timing: an accepted request goes through the compute steps in order
// (pointer and alignment mask, padding and resize checks, room check and
// offset update); the last one writes the result to the output register.
// a new request is accepted only once the previous one has committed; the
// next request is accepted while the result waits.
// when the receiver stalls, the last compute step holds until the output
// register frees, so nothing is lost or repeated.
// reset: both offsets clear, base address 0, capacity 65536, no result
// pending.
module arena_bump_allocator
	import aba_pkg::*;
#(
	parameter int ADDRESS_WIDTH = ADDR_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// alloc_size, alignment, blk_address, blk_size, marker_prev, marker_curr
	input  logic [6*DATA_W-1:0]  s_tdata,
	// op
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// address, saved_prev, saved_curr
	output logic [3*DATA_W-1:0]  m_tdata,
	// status
	output logic [STATUS_W-1:0]  m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	aba_cmd_t cmd;

	assign cfg_ready = 1'b1;

	aba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	aba_datapath #(
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (s_tuser),
		.alloc_size  (s_tdata[DATA_W-1:0]),
		.alignment   (s_tdata[2*DATA_W-1:DATA_W]),
		.blk_address (s_tdata[3*DATA_W-1:2*DATA_W]),
		.blk_size    (s_tdata[4*DATA_W-1:3*DATA_W]),
		.marker_prev (s_tdata[5*DATA_W-1:4*DATA_W]),
		.marker_curr (s_tdata[6*DATA_W-1:5*DATA_W]),
		.status      (m_tuser),
		.address     (m_tdata[DATA_W-1:0]),
		.saved_prev  (m_tdata[2*DATA_W-1:DATA_W]),
		.saved_curr  (m_tdata[3*DATA_W-1:2*DATA_W])
	);

endmodule

// ----- tb/sv/arena_bump_allocator_test.sv -----
`timescale 1ns / 1ps

module arena_bump_allocator_test;
	import aba_pkg::*;

	localparam int ADDR_W          = ADDR_W_DEF;
	localparam logic [63:0] ADDR_MASK = (ADDR_W >= 64) ? '1 : ((64'd1 << ADDR_W) - 64'd1);
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int STALL_HOLD      = 80;
	localparam int REPORT_LIMIT    = 10;
	localparam int BLOCK_HISTORY   = 8;

	// op codes the block treats as no-ops
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [31:0]     alloc_size;
		logic [31:0]     alignment;
		logic [31:0]     blk_address;
		logic [31:0]     blk_size;
		logic [31:0]     marker_prev;
		logic [31:0]     marker_curr;
	} alloc_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [31:0]         address;
		logic [31:0]         saved_prev;
		logic [31:0]         saved_curr;
	} alloc_res_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [6*DATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]      s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [3*DATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	// arena model: registers and offsets
	logic [31:0] arena_base = '0;
	logic [31:0] arena_cap  = CAP_RESET;
	logic [31:0] mark_last  = '0;
	logic [31:0] mark_top   = '0;

	alloc_res_t  pending_results[$];
	logic [31:0] block_addr_q[$];
	logic [31:0] block_size_q[$];
	logic [31:0] kept_prev;
	logic [31:0] kept_curr;
	bit          have_marker = 1'b0;

	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          hold_ask   = 0;
	int          stall_left = 0;
	int          fail_count = 0;
	int          idle_cycles = 0;
	alloc_res_t  got_res;
	alloc_res_t  want_res;

	arena_bump_allocator #(
		.ADDRESS_WIDTH(ADDR_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_pow2(logic [63:0] x);
		return x != 64'd0 && (x & (x - 64'd1)) == 64'd0;
	endfunction

	// bump the free offset by a block aligned on the absolute pointer
	function automatic logic [STATUS_W-1:0] bump_block(logic [63:0] size, logic [63:0] align,
			output logic [31:0] addr);
		logic [63:0] cur, mis, pad, off;
		addr = '0;
		if (!is_pow2(align))
			return ST_ALIGN;
		cur = ({32'd0, arena_base} + {32'd0, mark_top}) & ADDR_MASK;
		mis = cur & (align - 64'd1);
		pad = (mis != 64'd0) ? (align - mis) : 64'd0;
		off = {32'd0, mark_top} + pad;
		if (off > {32'd0, arena_cap} || size > {32'd0, arena_cap} - off)
			return ST_ROOM;
		addr = 32'(({32'd0, arena_base} + off) & ADDR_MASK);
		mark_last = off[31:0];
		mark_top = 32'(off + size);
		return ST_OK;
	endfunction

	function automatic logic [STATUS_W-1:0] resize_block(logic [63:0] nsz, logic [63:0] align,
			logic [63:0] oaddr, logic [63:0] osz, output logic [31:0] addr);
		logic [63:0] ooff;
		addr = '0;
		if (oaddr == 64'd0 || oaddr < {32'd0, arena_base})
			return ST_ADDR;
		ooff = oaddr - {32'd0, arena_base};
		if (ooff >= {32'd0, arena_cap})
			return ST_ADDR;
		if (osz == 64'd0 || nsz == 64'd0)
			return ST_ZERO;
		if (!is_pow2(align))
			return ST_ALIGN;
		if (osz == nsz) begin
			addr = oaddr[31:0];
			return ST_OK;
		end
		if (nsz > {32'd0, arena_cap} - ooff)
			return ST_ROOM;
		// last block grows or shrinks where it stands, top wraps on bad old sizes
		if (ooff == {32'd0, mark_last}) begin
			if (osz >= nsz)
				mark_top = mark_top - 32'(osz - nsz);
			else
				mark_top = mark_top + 32'(nsz - osz);
			addr = oaddr[31:0];
			return ST_OK;
		end
		return bump_block(nsz, align, addr);
	endfunction

	function automatic alloc_res_t compute_arena_result(alloc_req_t r);
		alloc_res_t          e;
		logic [31:0]         a;
		logic [STATUS_W-1:0] st;
		a = '0;
		st = ST_OK;
		case (r.op)
			OP_ALLOC: begin
				st = bump_block({32'd0, r.alloc_size}, {32'd0, r.alignment}, a);
			end
			OP_RESIZE: begin
				st = resize_block({32'd0, r.alloc_size}, {32'd0, r.alignment},
					{32'd0, r.blk_address}, {32'd0, r.blk_size}, a);
			end
			OP_RESET: begin
				mark_last = '0;
				mark_top = '0;
			end
			OP_RESTORE: begin
				mark_last = r.marker_prev;
				mark_top = r.marker_curr;
			end
			default: ;
		endcase
		if (st != ST_OK)
			a = '0;
		e.status = st;
		e.address = a;
		e.saved_prev = mark_last;
		e.saved_curr = mark_top;
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] pick_size();
		int          r;
		logic [31:0] span;
		r = $urandom_range(0, 99);
		span = (arena_cap >= 32'd2048) ? 32'd256 : (arena_cap >> 3);
		if (r < 80)
			return $urandom_range(0, span);
		if (r < 95)
			return $urandom_range(0, arena_cap);
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_alignment();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 32'd1 << $urandom_range(0, 6);
		if (r < 93)
			return 32'd1 << $urandom_range(7, 31);
		if (r < 96)
			return '0;
		return $urandom();
	endfunction

	function automatic alloc_req_t make_req(logic [OP_W-1:0] op, logic [31:0] size,
			logic [31:0] align, logic [31:0] oaddr, logic [31:0] osz,
			logic [31:0] mprev, logic [31:0] mcurr);
		alloc_req_t r;
		r.op = op;
		r.alloc_size = size;
		r.alignment = align;
		r.blk_address = oaddr;
		r.blk_size = osz;
		r.marker_prev = mprev;
		r.marker_curr = mcurr;
		return r;
	endfunction

	// mostly well-formed requests against the current arena, the rest noise
	function automatic alloc_req_t random_request();
		alloc_req_t r;
		int         pick;
		int         k;
		r = make_req(OP_W'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom());
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.op = OP_ALLOC;
			r.alloc_size = pick_size();
			r.alignment = pick_alignment();
		end else if (pick < 60) begin
			r.op = OP_RESIZE;
			r.blk_address = arena_base + mark_last;
			r.blk_size = mark_top - mark_last;
			r.alloc_size = ($urandom_range(0, 9) == 0) ? r.blk_size : pick_size();
			r.alignment = pick_alignment();
		end else if (pick < 70 && block_addr_q.size() != 0) begin
			k = $urandom_range(0, block_addr_q.size() - 1);
			r.op = OP_RESIZE;
			r.blk_address = block_addr_q[k];
			r.blk_size = block_size_q[k];
			r.alloc_size = pick_size();
			r.alignment = pick_alignment();
		end else if (pick < 75) begin
			r.op = OP_RESIZE;
			if ($urandom_range(0, 1) == 1)
				r.blk_address = arena_base + $urandom_range(0, arena_cap);
		end else if (pick < 83) begin
			r.op = OP_READ;
		end else if (pick < 90) begin
			r.op = OP_RESTORE;
			if (have_marker && $urandom_range(0, 9) < 7) begin
				r.marker_prev = kept_prev;
				r.marker_curr = kept_curr;
			end
		end else if (pick < 94) begin
			r.op = OP_RESET;
		end else if (pick < 97) begin
			r.op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		end
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input alloc_req_t r);
		int         gap;
		alloc_res_t e;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {r.marker_curr, r.marker_prev, r.blk_size, r.blk_address, r.alignment,
			r.alloc_size};
		do @(posedge clk); while (!s_tready);
		e = compute_arena_result(r);
		pending_results.push_back(e);
		if ((r.op == OP_ALLOC || r.op == OP_RESIZE) && e.status == ST_OK && r.alloc_size != 0) begin
			block_addr_q.push_back(e.address);
			block_size_q.push_back(r.alloc_size);
			if (block_addr_q.size() > BLOCK_HISTORY) begin
				void'(block_addr_q.pop_front());
				void'(block_size_q.pop_front());
			end
		end
		if (r.op == OP_READ) begin
			kept_prev = e.saved_prev;
			kept_curr = e.saved_curr;
			have_marker = 1'b1;
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BASE)
			arena_base = value;
		else
			arena_cap = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random_chunk(input int n);
		tx_idle_on = ($urandom_range(0, 3) != 0);
		rx_idle_on = ($urandom_range(0, 3) != 0);
		repeat (n) send_request(random_request());
	endtask

	// runs from reset: base 0, capacity 65536
	task automatic test_directed_ops();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// zero size at offset zero, then an unaligned top
		send_request(make_req(OP_ALLOC, 32'd0, 32'd1, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'd5, 32'd1, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'd16, 32'd8, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'd4, 32'd0, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'd4, 32'd12, '0, '0, '0, '0));
		// padding alone runs past capacity
		send_request(make_req(OP_ALLOC, 32'd0, 32'h8000_0000, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd1, '0, '0, '0, '0));
		// resize checks in their order
		send_request(make_req(OP_RESIZE, 32'd8, 32'd4, 32'd0, 32'd16, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd8, 32'd4, 32'd65536, 32'd16, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd4, 32'd4, 32'd8, 32'd0, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd0, 32'd4, 32'd8, 32'd16, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd32, 32'd3, 32'd8, 32'd16, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd16, 32'd4, 32'd8, 32'd16, '0, '0));
		// last block shrinks, grows, then cannot fit
		send_request(make_req(OP_RESIZE, 32'd4, 32'd4, 32'd8, 32'd16, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd100, 32'd4, 32'd8, 32'd4, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd65536, 32'd4, 32'd8, 32'd100, '0, '0));
		// older block moves to the end
		send_request(make_req(OP_ALLOC, 32'd20, 32'd16, '0, '0, '0, '0));
		send_request(make_req(OP_RESIZE, 32'd40, 32'd4, 32'd8, 32'd100, '0, '0));
		// inconsistent old size wraps the top offset
		send_request(make_req(OP_RESIZE, 32'd1, 32'd4, 32'd132, 32'hFFFF_0000, '0, '0));
		send_request(make_req(OP_READ, '0, '0, '0, '0, '0, '0));
		// top restored past capacity
		send_request(make_req(OP_RESTORE, '0, '0, '0, '0, 32'd16, 32'hFFFF_FFF0));
		send_request(make_req(OP_ALLOC, 32'd1, 32'd1, '0, '0, '0, '0));
		// fill to exactly capacity, then a zero size block at the very end
		send_request(make_req(OP_RESTORE, '0, '0, '0, '0, 32'd24, 32'd24));
		send_request(make_req(OP_ALLOC, 32'd65512, 32'd1, '0, '0, '0, '0));
		send_request(make_req(OP_ALLOC, 32'd0, 32'd1, '0, '0, '0, '0));
		send_request(make_req(OP_RESET, '0, '0, '0, '0, '0, '0));
		send_request(make_req(OP_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
	endtask

	task automatic test_random_traffic();
		repeat (6) run_random_chunk(25);
	endtask

	// receiver holds off while requests keep coming, so the input must back up
	task automatic test_output_stall();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_ask = STALL_HOLD;
		repeat (16) send_request(random_request());
		drain_results();
	endtask

	task automatic test_register_settings();
		logic [31:0] bases [5] = '{32'h1000_0003, 32'hFFFF_F000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0000_8000};
		logic [31:0] caps [5] = '{32'd4096, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'h0010_0000};
		for (int i = 0; i < 5; i++) begin
			drain_results();
			write_register(CFG_BASE, bases[i]);
			write_register(CFG_CAP, caps[i]);
			run_random_chunk(25);
			run_random_chunk(25);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_ops();
		test_random_traffic();
		test_output_stall();
		test_register_settings();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("arena_bump_allocator_test: clean");
		end else begin
			$display("arena_bump_allocator_test: errors");
		end
		$finish;
	end

	// result side pacing; a requested hold is counted out here
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_ask > 0) begin
				stall_left = hold_ask;
				hold_ask = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.status = m_tuser;
			got_res.address = m_tdata[31:0];
			got_res.saved_prev = m_tdata[63:32];
			got_res.saved_curr = m_tdata[95:64];
			if (pending_results.size() == 0) begin
				fail_count = fail_count + 1;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result word: status %0d address %h prev %h curr %h",
						got_res.status, got_res.address, got_res.saved_prev, got_res.saved_curr);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.status !== want_res.status || got_res.address !== want_res.address ||
						got_res.saved_prev !== want_res.saved_prev ||
						got_res.saved_curr !== want_res.saved_curr) begin
					fail_count = fail_count + 1;
					if (fail_count <= REPORT_LIMIT)
						$display({"result mismatch (expected/actual): status %0d/%0d ",
							"address %h/%h prev %h/%h curr %h/%h"},
							want_res.status, got_res.status, want_res.address, got_res.address,
							want_res.saved_prev, got_res.saved_prev,
							want_res.saved_curr, got_res.saved_curr);
				end
			end
		end
	end

	// no word moving on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("arena_bump_allocator_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
